[rtl/tsb_pkg.sv]
// Shared types and constants of the bilinear texture sampler.
`default_nettype none
package tsb_pkg;
   localparam int STORE_DEPTH = 65536;
   localparam int STORE_AW    = 16;
   localparam int ARGB_W      = 32;
   localparam int CSR_W       = 9;
   localparam int WEIGHT_W    = 17;
   localparam int DEF_MAX_TEX_WIDTH  = 256;
   localparam int DEF_MAX_TEX_HEIGHT = 256;

   localparam logic [1:0] MODE_WRITE    = 2'd0;
   localparam logic [1:0] MODE_NEAREST  = 2'd1;
   localparam logic [1:0] MODE_BILINEAR = 2'd2;

   localparam logic REG_TEX_WIDTH  = 1'b0;
   localparam logic REG_TEX_HEIGHT = 1'b1;

   // Taps are ordered 00, 10, 01, 11 (column, row).
   typedef struct packed {
      logic                             sample;
      logic                             write;
      logic [3:0][STORE_AW-1:0]         addr;
      logic [3:0][WEIGHT_W-1:0]         weight;
      logic [STORE_AW-1:0]              wr_addr;
      logic [ARGB_W-1:0]                wr_data;
   } fetch_type;
endpackage
`default_nettype wire

[rtl/tsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/tsb_addr.sv]
// Address pipeline: coordinate scaling, edge clamping, addresses and weights.
`default_nettype none
module tsb_addr import tsb_pkg::*; #(
   parameter int MAX_TEX_WIDTH  = DEF_MAX_TEX_WIDTH,
   parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                req_valid,
   input  wire logic [1:0]          mode,
   input  wire logic [15:0]         frac_u,
   input  wire logic [15:0]         frac_v,
   input  wire logic [15:0]         texel_index,
   input  wire logic [ARGB_W-1:0]   texel_argb,
   input  wire logic [CSR_W-1:0]    tex_width,
   input  wire logic [CSR_W-1:0]    tex_height,
   output fetch_type                fetch
);
   localparam int SZW = $clog2((MAX_TEX_WIDTH > MAX_TEX_HEIGHT ?
                                MAX_TEX_WIDTH : MAX_TEX_HEIGHT) + 1);
   localparam int TW  = 17 + SZW;
   localparam int FW  = (2 * SZW + 1 > STORE_AW) ? 2 * SZW + 1 : STORE_AW;

   logic [SZW-1:0] eff_w, eff_h;

   always_comb begin
      if (tex_width == '0) eff_w = SZW'(1);
      else if (32'(tex_width) > 32'(MAX_TEX_WIDTH)) eff_w = SZW'(MAX_TEX_WIDTH);
      else eff_w = SZW'(tex_width);
      if (tex_height == '0) eff_h = SZW'(1);
      else if (32'(tex_height) > 32'(MAX_TEX_HEIGHT)) eff_h = SZW'(MAX_TEX_HEIGHT);
      else eff_h = SZW'(tex_height);
   end

   // Stage 1: registered transaction.
   logic                s1_ff, w1_ff, bil1_ff;
   logic [15:0]         fu1_ff, fv1_ff, idx1_ff;
   logic [ARGB_W-1:0]   argb1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         w1_ff <= 1'b0;
      end else if (en) begin
         s1_ff <= req_valid && (mode == MODE_NEAREST || mode == MODE_BILINEAR);
         w1_ff <= req_valid && (mode == MODE_WRITE);
      end
      if (en) begin
         bil1_ff  <= (mode == MODE_BILINEAR);
         fu1_ff   <= frac_u;
         fv1_ff   <= frac_v;
         idx1_ff  <= texel_index;
         argb1_ff <= texel_argb;
      end
   end

   // Stage 2: scale fractions by the texture size, with the half-texel bias in bilinear mode.
   logic                s2_ff, w2_ff, bil2_ff;
   logic [TW-1:0]       tx2_ff, ty2_ff;
   logic [15:0]         idx2_ff;
   logic [ARGB_W-1:0]   argb2_ff;
   logic [TW-1:0]       tx2_in, ty2_in, bias;

   always_comb begin
      bias   = bil1_ff ? TW'(32768) : '0;
      tx2_in = TW'(fu1_ff) * TW'(eff_w) + bias;
      ty2_in = TW'(fv1_ff) * TW'(eff_h) + bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= 1'b0;
         w2_ff <= 1'b0;
      end else if (en) begin
         s2_ff <= s1_ff;
         w2_ff <= w1_ff;
      end
      if (en) begin
         bil2_ff  <= bil1_ff;
         tx2_ff   <= tx2_in;
         ty2_ff   <= ty2_in;
         idx2_ff  <= idx1_ff;
         argb2_ff <= argb1_ff;
      end
   end

   // Stage 3: clamp the footprint to the edges and take the weights.
   logic                s3_ff, w3_ff;
   logic [SZW-1:0]      cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic [SZW-1:0]      cx0_in, cx1_in, cy0_in, cy1_in;
   logic [7:0]          wx3_ff, wy3_ff, wx3_in, wy3_in;
   logic [15:0]         idx3_ff;
   logic [ARGB_W-1:0]   argb3_ff;
   logic [SZW:0]        hx, hy;

   always_comb begin
      hx = tx2_ff[TW-1:16];
      hy = ty2_ff[TW-1:16];
      if (bil2_ff) begin
         // The low tap sits one texel below the integer part.
         cx0_in = (hx == '0) ? '0 : SZW'(hx - 1'b1);
         cy0_in = (hy == '0) ? '0 : SZW'(hy - 1'b1);
         cx1_in = (hx > (SZW+1)'(eff_w - 1'b1)) ? eff_w - 1'b1 : SZW'(hx);
         cy1_in = (hy > (SZW+1)'(eff_h - 1'b1)) ? eff_h - 1'b1 : SZW'(hy);
         wx3_in = tx2_ff[15:8];
         wy3_in = ty2_ff[15:8];
      end else begin
         // Nearest uses tap 00 alone with full weight.
         cx0_in = SZW'(hx);
         cy0_in = SZW'(hy);
         cx1_in = SZW'(hx);
         cy1_in = SZW'(hy);
         wx3_in = '0;
         wy3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= 1'b0;
         w3_ff <= 1'b0;
      end else if (en) begin
         s3_ff <= s2_ff;
         w3_ff <= w2_ff;
      end
      if (en) begin
         cx0_ff   <= cx0_in;
         cx1_ff   <= cx1_in;
         cy0_ff   <= cy0_in;
         cy1_ff   <= cy1_in;
         wx3_ff   <= wx3_in;
         wy3_ff   <= wy3_in;
         idx3_ff  <= idx2_ff;
         argb3_ff <= argb2_ff;
      end
   end

   // Stage 4: linear addresses and the four blend weights.
   fetch_type           fetch_ff, fetch_in;
   logic [FW-1:0]       row0, row1;
   logic [8:0]          ax, ay;

   always_comb begin
      row0 = FW'(cy0_ff) * FW'(eff_w);
      row1 = FW'(cy1_ff) * FW'(eff_w);
      ax   = 9'd256 - 9'(wx3_ff);
      ay   = 9'd256 - 9'(wy3_ff);
      fetch_in.sample    = s3_ff;
      fetch_in.write     = w3_ff;
      fetch_in.addr[0]   = STORE_AW'(row0 + FW'(cx0_ff));
      fetch_in.addr[1]   = STORE_AW'(row0 + FW'(cx1_ff));
      fetch_in.addr[2]   = STORE_AW'(row1 + FW'(cx0_ff));
      fetch_in.addr[3]   = STORE_AW'(row1 + FW'(cx1_ff));
      fetch_in.weight[0] = WEIGHT_W'(18'(ax) * 18'(ay));
      fetch_in.weight[1] = WEIGHT_W'(18'(wx3_ff) * 18'(ay));
      fetch_in.weight[2] = WEIGHT_W'(18'(ax) * 18'(wy3_ff));
      fetch_in.weight[3] = WEIGHT_W'(18'(wx3_ff) * 18'(wy3_ff));
      fetch_in.wr_addr   = idx3_ff;
      fetch_in.wr_data   = argb3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff.sample <= 1'b0;
         fetch_ff.write  <= 1'b0;
      end else if (en) begin
         fetch_ff.sample <= fetch_in.sample;
         fetch_ff.write  <= fetch_in.write;
      end
      if (en) begin
         fetch_ff.addr    <= fetch_in.addr;
         fetch_ff.weight  <= fetch_in.weight;
         fetch_ff.wr_addr <= fetch_in.wr_addr;
         fetch_ff.wr_data <= fetch_in.wr_data;
      end
   end

   assign fetch = fetch_ff;

   a_eff_size: assert property (@(posedge clock) disable iff (reset)
      eff_w != '0 && 32'(eff_w) <= 32'(MAX_TEX_WIDTH) &&
      eff_h != '0 && 32'(eff_h) <= 32'(MAX_TEX_HEIGHT))
      else $error("effective texture size out of range");
   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      s3_ff |-> (cx1_ff < eff_w && cx0_ff <= cx1_ff))
      else $error("column taps not clamped to the texture");
   a_clamp_y: assert property (@(posedge clock) disable iff (reset)
      s3_ff |-> (cy1_ff < eff_h && cy0_ff <= cy1_ff))
      else $error("row taps not clamped to the texture");
endmodule
`default_nettype wire

[rtl/tsb_blend.sv]
// Blend pipeline: per-channel weighted sum of the four texels.
`default_nettype none
module tsb_blend import tsb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  fetch_type                   fetch,
   input  wire logic [3:0][ARGB_W-1:0] texel,
   output logic                        out_valid,
   output logic [ARGB_W-1:0]           out_argb
);
   localparam int PW = 8 + WEIGHT_W;
   localparam int AW = PW + 2;

   // Stage B1 lines up with the registered RAM read data.
   logic                      s1_ff, s2_ff, s3_ff;
   logic [3:0][WEIGHT_W-1:0]  k1_ff;
   logic [3:0][3:0][PW-1:0]   prod_ff, prod_in;
   logic [ARGB_W-1:0]         argb_ff, argb_in;
   logic [AW-1:0]             acc;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int t = 0; t < 4; t++) begin
            prod_in[c][t] = PW'(texel[t][8*c +: 8]) * PW'(k1_ff[t]);
         end
      end
      argb_in = '0;
      for (int c = 0; c < 4; c++) begin
         acc = AW'(prod_ff[c][0]) + AW'(prod_ff[c][1])
             + AW'(prod_ff[c][2]) + AW'(prod_ff[c][3]);
         argb_in[8*c +: 8] = acc[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else if (en) begin
         s1_ff <= fetch.sample;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
      if (en) begin
         k1_ff   <= fetch.weight;
         prod_ff <= prod_in;
         argb_ff <= argb_in;
      end
   end

   assign out_valid = s3_ff;
   assign out_argb  = argb_ff;
endmodule
`default_nettype wire

[rtl/texture_sampler_bilinear.sv]
// Top level of the bilinear texture sampler with clamp-to-edge addressing.
// A sample transaction passes the address stages, the RAM read and the blend registers to rsp_.
// Throughput: one transaction per cycle when not stalled; the four texels come from four
// replicated texel RAMs, each read once per cycle, all written together.
// Back-pressure stalls the whole pipeline in place.
// Reset clears the pipeline valid bits and sets both sizes to 256; texel RAM keeps its contents.
`default_nettype none
module texture_sampler_bilinear import tsb_pkg::*; #(
   parameter int MAX_TEX_WIDTH  = DEF_MAX_TEX_WIDTH,
   parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_mode,
   input  wire logic signed [31:0]  req_coord_u,
   input  wire logic signed [31:0]  req_coord_v,
   input  wire logic [15:0]         req_texel_index,
   input  wire logic [ARGB_W-1:0]   req_texel_argb,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [ARGB_W-1:0]        rsp_sample_argb,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [CSR_W-1:0]    csr_wr_data
);
   logic [CSR_W-1:0]          tex_width_ff, tex_height_ff;
   logic                      en;
   fetch_type                 fetch;
   logic [3:0][ARGB_W-1:0]    texel;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= CSR_W'(256);
         tex_height_ff <= CSR_W'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TEX_WIDTH:  tex_width_ff  <= csr_wr_data;
            REG_TEX_HEIGHT: tex_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   tsb_addr #(
      .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
      .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT)
   ) u_addr (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .mode        (req_mode),
      .frac_u      (req_coord_u[15:0]),
      .frac_v      (req_coord_v[15:0]),
      .texel_index (req_texel_index),
      .texel_argb  (req_texel_argb),
      .tex_width   (tex_width_ff),
      .tex_height  (tex_height_ff),
      .fetch       (fetch)
   );

   // Writes land in the same stage that reads, so transaction order holds.
   for (genvar t = 0; t < 4; t++) begin : g_bank
      tsb_ram #(
         .WIDTH (ARGB_W),
         .DEPTH (STORE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (en && fetch.write),
         .wr_addr (fetch.wr_addr),
         .wr_data (fetch.wr_data),
         .rd_en   (en),
         .rd_addr (fetch.addr[t]),
         .rd_data (texel[t])
      );
   end

   tsb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .fetch     (fetch),
      .texel     (texel),
      .out_valid (rsp_valid),
      .out_argb  (rsp_sample_argb)
   );
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the bilinear texture sampler.
`timescale 1ns / 1ps
module tb_top;
   import tsb_pkg::*;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] u;
      logic [31:0] v;
      logic [15:0] index;
      logic [31:0] argb;
   } tex_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [1:0]  req_mode = MODE_WRITE;
   logic [31:0] req_coord_u = '0;
   logic [31:0] req_coord_v = '0;
   logic [15:0] req_texel_index = '0;
   logic [31:0] req_texel_argb = '0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [31:0] rsp_sample_argb;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = REG_TEX_WIDTH;
   logic [8:0]  csr_wr_data = '0;

   texture_sampler_bilinear uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_coord_u(req_coord_u), .req_coord_v(req_coord_v),
      .req_texel_index(req_texel_index), .req_texel_argb(req_texel_argb),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_argb(rsp_sample_argb),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   tex_req_type pending_reqs[$];
   logic [31:0] expected_samples[$];
   logic [31:0] texels[int];     // contents in acceptance order
   bit          planned[int];    // entries that have a write queued
   int          size_w = 256;
   int          size_h = 256;
   int          errors = 0;
   bit          quiet = 0;
   bit          long_hold = 0;
   bit          req_busy = 0;
   tex_req_type cur;
   int          tx_gap = 0;
   int          rx_gap = 0;
   int          hold_count = 0;
   int          stuck_cycles = 0;

   function automatic logic [31:0] read_texel(int x, int y);
      int cx, cy;
      cx = x < 0 ? 0 : (x > size_w - 1 ? size_w - 1 : x);
      cy = y < 0 ? 0 : (y > size_h - 1 ? size_h - 1 : y);
      return texels[(cy * size_w + cx) & 16'hFFFF];
   endfunction

   function automatic logic [31:0] sample_color(tex_req_type r);
      logic [31:0] fu, fv, tx, ty, wx, wy, acc, color;
      logic [31:0] p[4];
      logic [31:0] k[4];
      int x0, y0;
      fu = {16'h0, r.u[15:0]};
      fv = {16'h0, r.v[15:0]};
      if (r.mode == MODE_NEAREST)
         return read_texel(int'((fu * size_w) >> 16), int'((fv * size_h) >> 16));
      tx = fu * size_w + 32'h8000;
      ty = fv * size_h + 32'h8000;
      x0 = int'(tx >> 16) - 1;
      y0 = int'(ty >> 16) - 1;
      wx = (tx >> 8) & 32'hFF;
      wy = (ty >> 8) & 32'hFF;
      p[0] = read_texel(x0, y0);
      p[1] = read_texel(x0 + 1, y0);
      p[2] = read_texel(x0, y0 + 1);
      p[3] = read_texel(x0 + 1, y0 + 1);
      k[0] = (256 - wx) * (256 - wy);
      k[1] = wx * (256 - wy);
      k[2] = (256 - wx) * wy;
      k[3] = wx * wy;
      color = '0;
      for (int sh = 0; sh < 32; sh += 8) begin
         acc = 0;
         for (int i = 0; i < 4; i++)
            acc += ((p[i] >> sh) & 32'hFF) * k[i];
         color |= ((acc >> 16) & 32'hFF) << sh;
      end
      return color;
   endfunction

   // Sender: acceptance bookkeeping at the rising edge, new payload at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (cur.mode == MODE_WRITE)
            texels[cur.index] = cur.argb;
         else if (cur.mode == MODE_NEAREST || cur.mode == MODE_BILINEAR)
            expected_samples.push_back(sample_color(cur));
         req_busy <= 0;
      end
   end

   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur = pending_reqs.pop_front();
            req_mode <= cur.mode;
            req_coord_u <= cur.u;
            req_coord_v <= cur.v;
            req_texel_index <= cur.index;
            req_texel_argb <= cur.argb;
            req_valid <= 1'b1;
            req_busy <= 1;
            if (!quiet && $urandom_range(0, 9) == 0)
               tx_gap <= $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver with random stall bursts and one long hold-off.
   always @(negedge clock) begin
      if (long_hold && hold_count < 300) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rx_gap <= $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_argb: expected none, actual %h", rsp_sample_argb);
            errors++;
         end else begin
            logic [31:0] want;
            want = expected_samples.pop_front();
            if (rsp_sample_argb !== want) begin
               $error("sample_argb: expected %h, actual %h", want, rsp_sample_argb);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en ||
          (pending_reqs.size() == 0 && expected_samples.size() == 0 && !req_busy))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles > 2000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_req(logic [1:0] mode, logic [31:0] u, logic [31:0] v,
                           logic [15:0] index, logic [31:0] argb);
      tex_req_type r;
      r.mode = mode; r.u = u; r.v = v; r.index = index; r.argb = argb;
      if (mode == MODE_WRITE)
         planned[index] = 1;
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && expected_samples.size() == 0 && !req_busy);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_size(logic [8:0] w, logic [8:0] h);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= REG_TEX_WIDTH; csr_wr_data <= w;
      @(negedge clock);
      csr_index <= REG_TEX_HEIGHT; csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      size_w = w == 0 ? 1 : (w > 256 ? 256 : w);
      size_h = h == 0 ? 1 : (h > 256 ? 256 : h);
   endtask

   // Every texel a sample can reach must hold a written value.
   task automatic fill_area();
      for (int i = 0; i < size_w * size_h; i++)
         if (!planned.exists(i))
            push_req(MODE_WRITE, $urandom, $urandom, i, $urandom);
   endtask

   task automatic random_reqs(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            push_req(MODE_BILINEAR, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 72)
            push_req(MODE_NEAREST, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 82)
            push_req(MODE_WRITE, $urandom, $urandom,
                     $urandom_range(0, size_w * size_h - 1), $urandom);
         else if (pick < 90)
            push_req(MODE_WRITE, $urandom, $urandom, $urandom, $urandom);
         else
            push_req(2'd3, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a 2x2 texture with extreme colors, edges and wrap.
      set_size(2, 2);
      push_req(MODE_WRITE, 0, 0, 0, 32'h0000_0000);
      push_req(MODE_WRITE, 0, 0, 1, 32'hFFFF_FFFF);
      push_req(MODE_WRITE, 0, 0, 2, 32'hFF00_FF00);
      push_req(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 32'h00FF_00FF);
      push_req(MODE_WRITE, 0, 0, 16'hFFFF, 32'h1234_5678);
      push_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(MODE_NEAREST, 0, 0, 0, 0);
      push_req(MODE_NEAREST, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0);
      push_req(MODE_NEAREST, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0);
      push_req(MODE_NEAREST, 32'h7FFF_FFFF, 32'h0000_8000, 0, 0);
      push_req(MODE_BILINEAR, 0, 0, 0, 0);
      push_req(MODE_BILINEAR, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0);
      push_req(MODE_BILINEAR, 32'h0000_4000, 32'h0000_4000, 0, 0);
      push_req(MODE_BILINEAR, 32'h0000_8000, 32'h0000_C000, 0, 0);
      push_req(MODE_BILINEAR, 32'h8000_6000, 32'h7FFF_2000, 0, 0);
      push_req(MODE_BILINEAR, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0);

      set_size(256, 1);  fill_area(); random_reqs(40);
      set_size(1, 256);  fill_area(); random_reqs(40);
      set_size(0, 511);  fill_area(); random_reqs(40);
      set_size(1, 1);    fill_area(); random_reqs(30);
      set_size(16, 16);  fill_area();
      wait (pending_reqs.size() == 0);
      // Hold the receiver off while samples keep coming so the pipeline backs up.
      for (int i = 0; i < 60; i++)
         push_req(MODE_BILINEAR, $urandom, $urandom, $urandom, $urandom);
      long_hold = 1;
      random_reqs(30);
      set_size(300, 0);  fill_area(); random_reqs(40);
      set_size(7, 13);   fill_area(); random_reqs(40);
      set_size(20, 14);  fill_area();
      wait (pending_reqs.size() == 0);
      quiet = 1;
      random_reqs(60);

      wait (pending_reqs.size() == 0 && expected_samples.size() == 0 && !req_busy);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
